// ===== rtl/rth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/triangle hit test package
// Shared field widths for the ray/triangle hit test channels.
// ----------------------------------------------------------------------------
package rth_pkg;
    localparam int unsigned FIELD_W = 60;
    typedef logic [FIELD_W-1:0] t_field;
endpackage
`default_nettype wire

// ===== rtl/rth_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/triangle input channel
// Valid/ready channel carrying one ray and one triangle per beat.
// ----------------------------------------------------------------------------
interface rth_in_if;
    logic            valid;
    logic            ready;
    rth_pkg::t_field ray_origin;
    rth_pkg::t_field ray_direction;
    rth_pkg::t_field vertex_zero;
    rth_pkg::t_field vertex_one;
    rth_pkg::t_field vertex_two;

    modport source (output valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                    vertex_two, input ready);
    modport sink   (input valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                    vertex_two, output ready);
endinterface
`default_nettype wire

// ===== rtl/rth_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/triangle result channel
// Valid/ready channel carrying one hit flag per beat.
// ----------------------------------------------------------------------------
interface rth_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface
`default_nettype wire

// ===== rtl/ray_triangle_hit_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/triangle hit test unit
// Exact fixed-point ray/triangle test: origin-in-triangle check, face-side
// rejection and three scalar triple products, in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  dir  signals                                         beat
//  i_in     in   valid ready ray_origin ray_direction vertex_*  one ray+triangle
//  o_out    out  valid ready hit                                 one hit flag
//
//  Beats pass through stages 1 to 4 in order; one beat per cycle while the output is not stalled.
//  Stage 1 takes differences, stage 2 cross and short dot products, stage 3
//  wide dot products and split partial products, stage 4 signs and decision.
//  Reset clears all stage valid bits.
//  A stalled output freezes every stage; i_in.ready follows the output slot.
// ----------------------------------------------------------------------------
module ray_triangle_hit_test_unit #(
    parameter int unsigned COORD_BITS = 20
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rth_in_if.sink    i_in,
    rth_out_if.source o_out
);
    import rth_pkg::*;

    localparam int unsigned CW = COORD_BITS;
    localparam int unsigned DW = CW + 1;
    localparam int unsigned NW = 2 * CW + 3;
    localparam int unsigned SW = 2 * CW + 4;
    localparam int unsigned WW = 3 * CW + 6;
    localparam int unsigned LW = SW / 2;
    localparam int unsigned HW = SW - LW;
    localparam int unsigned PW = 2 * SW + 1;

    typedef logic signed [DW-1:0] t_dv [3];
    typedef logic signed [NW-1:0] t_nv [3];

    function automatic logic signed [NW-1:0] xterm(input logic signed [DW-1:0] p,
            input logic signed [DW-1:0] q, input logic signed [DW-1:0] r,
            input logic signed [DW-1:0] s);
        logic signed [2*DW-1:0] m1;
        logic signed [2*DW-1:0] m2;
        m1 = p * q;
        m2 = r * s;
        return NW'(m1) - NW'(m2);
    endfunction

    function automatic t_nv xprod(input t_dv x, input t_dv y);
        t_nv r;
        r[0] = xterm(x[1], y[2], x[2], y[1]);
        r[1] = xterm(x[2], y[0], x[0], y[2]);
        r[2] = xterm(x[0], y[1], x[1], y[0]);
        return r;
    endfunction

    function automatic logic signed [SW-1:0] dot_s(input t_dv x, input t_dv y);
        logic signed [2*DW-1:0] m [3];
        for (int k = 0; k < 3; k++) m[k] = x[k] * y[k];
        return SW'(m[0]) + SW'(m[1]) + SW'(m[2]);
    endfunction

    function automatic logic signed [WW-1:0] dot_w(input t_nv x, input t_dv y);
        logic signed [NW+DW-1:0] m [3];
        for (int k = 0; k < 3; k++) m[k] = x[k] * y[k];
        return WW'(m[0]) + WW'(m[1]) + WW'(m[2]);
    endfunction

    function automatic logic signed [SW+LW:0] pp_lo(input logic signed [SW-1:0] x,
            input logic signed [SW-1:0] y);
        logic signed [LW:0] yl;
        yl = $signed({1'b0, y[LW-1:0]});
        return x * yl;
    endfunction

    function automatic logic signed [SW+HW-1:0] pp_hi(input logic signed [SW-1:0] x,
            input logic signed [SW-1:0] y);
        logic signed [HW-1:0] yh;
        yh = $signed(y[SW-1:LW]);
        return x * yh;
    endfunction

    function automatic logic signed [PW-1:0] pp_join(input logic signed [SW+LW:0] lo,
            input logic signed [SW+HW-1:0] hi);
        logic signed [PW-1:0] h;
        h = PW'(hi);
        return PW'(lo) + (h <<< LW);
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic ce;
    assign ce          = !r_v4 || o_out.ready;
    assign i_in.ready  = ce;

    // stage 1: differences
    t_dv  n_a, n_b, n_c, n_e1, n_e2, n_d;
    t_dv  r1_a, r1_b, r1_c, r1_e1, r1_e2, r1_d;

    always_comb begin
        logic signed [CW-1:0] o, d, p0, p1, p2;
        for (int k = 0; k < 3; k++) begin
            o  = $signed(i_in.ray_origin[k*CW +: CW]);
            d  = $signed(i_in.ray_direction[k*CW +: CW]);
            p0 = $signed(i_in.vertex_zero[k*CW +: CW]);
            p1 = $signed(i_in.vertex_one[k*CW +: CW]);
            p2 = $signed(i_in.vertex_two[k*CW +: CW]);
            n_a[k]  = DW'(p0) - DW'(o);
            n_b[k]  = DW'(p1) - DW'(o);
            n_c[k]  = DW'(p2) - DW'(o);
            n_e1[k] = DW'(p1) - DW'(p0);
            n_e2[k] = DW'(p2) - DW'(p0);
            n_d[k]  = DW'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_a  <= n_a;
            r1_b  <= n_b;
            r1_c  <= n_c;
            r1_e1 <= n_e1;
            r1_e2 <= n_e2;
            r1_d  <= n_d;
        end
    end

    // stage 2: normal, edge crosses, short dots
    t_nv r2_n, r2_cb, r2_ac, r2_ba;
    t_dv r2_a, r2_d;
    logic signed [SW-1:0] r2_ab, r2_acd, r2_bc, r2_cc, r2_bb;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_n   <= xprod(r1_e1, r1_e2);
            r2_cb  <= xprod(r1_c, r1_b);
            r2_ac  <= xprod(r1_a, r1_c);
            r2_ba  <= xprod(r1_b, r1_a);
            r2_a   <= r1_a;
            r2_d   <= r1_d;
            r2_ab  <= dot_s(r1_a, r1_b);
            r2_acd <= dot_s(r1_a, r1_c);
            r2_bc  <= dot_s(r1_b, r1_c);
            r2_cc  <= dot_s(r1_c, r1_c);
            r2_bb  <= dot_s(r1_b, r1_b);
        end
    end

    // stage 3: wide dots and split products
    logic signed [WW-1:0]   r3_na, r3_nd, r3_u, r3_v, r3_w;
    logic signed [SW+LW:0]  r3_l1, r3_l2, r3_l3, r3_l4;
    logic signed [SW+HW-1:0] r3_h1, r3_h2, r3_h3, r3_h4;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_na <= dot_w(r2_n, r2_a);
            r3_nd <= dot_w(r2_n, r2_d);
            r3_u  <= dot_w(r2_cb, r2_d);
            r3_v  <= dot_w(r2_ac, r2_d);
            r3_w  <= dot_w(r2_ba, r2_d);
            r3_l1 <= pp_lo(r2_bc, r2_acd);
            r3_h1 <= pp_hi(r2_bc, r2_acd);
            r3_l2 <= pp_lo(r2_cc, r2_ab);
            r3_h2 <= pp_hi(r2_cc, r2_ab);
            r3_l3 <= pp_lo(r2_ab, r2_bc);
            r3_h3 <= pp_hi(r2_ab, r2_bc);
            r3_l4 <= pp_lo(r2_acd, r2_bb);
            r3_h4 <= pp_hi(r2_acd, r2_bb);
        end
    end

    // stage 4: signs and decision
    logic n_hit, r_hit;

    always_comb begin
        logic signed [PW-1:0] q1, q2;
        logic na_pos, na_neg, nd_pos, nd_neg, in_tri, side_ok, tri_ok;
        q1 = pp_join(r3_l1, r3_h1) - pp_join(r3_l2, r3_h2);
        q2 = pp_join(r3_l3, r3_h3) - pp_join(r3_l4, r3_h4);
        na_neg  = r3_na[WW-1];
        na_pos  = !na_neg && (r3_na != '0);
        nd_neg  = r3_nd[WW-1];
        nd_pos  = !nd_neg && (r3_nd != '0);
        in_tri  = (r3_na == '0) && !q1[PW-1] && !q2[PW-1];
        side_ok = (nd_pos && na_pos) || (nd_neg && na_neg);
        tri_ok  = (r3_u[WW-1] && r3_v[WW-1] && r3_w[WW-1]) ||
                  (!r3_u[WW-1] && !r3_v[WW-1] && !r3_w[WW-1] &&
                   (r3_u != '0) && (r3_v != '0) && (r3_w != '0));
        n_hit   = in_tri || (side_ok && tri_ok);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (ce) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_out.valid = r_v4;
    assign o_out.hit   = r_hit;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !r_v4 && !r_v1)
        else $error("pipeline not empty after reset");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("accepted beat lost at stage 1");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !o_out.ready |=> r_v4 && $stable({r_v1, r_v2, r_v3}) && $stable(r_hit))
        else $error("pipeline moved during stall");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ce && r_v3 |=> r_v4)
        else $error("stage 3 beat dropped");
`endif

endmodule
`default_nettype wire
